// ===== rtl/core/rtksum_pkg.sv =====
`timescale 1ns / 1ps

package rtksum_pkg;

    localparam int MAX_KEEP   = 1024;
    localparam int ADDR_W     = $clog2(MAX_KEEP);
    localparam int FILL_W     = $clog2(MAX_KEEP + 1);
    // heap positions with room for 2*i+2
    localparam int POS_W      = ADDR_W + 2;
    localparam int SAMPLE_W   = 32;
    localparam int KEEP_W     = 11;
    localparam int KEPT_W     = 42;
    localparam int SUM_W      = SAMPLE_W + FILL_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = KEEP_W;
    localparam int CMP_W      = (KEEP_W > FILL_W) ? KEEP_W : FILL_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEEP_COUNT    = 2'd0,
        REG_KEEP_SMALLEST = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic                wr_en;
        logic [ADDR_W-1:0]   wr_addr;
        logic [SAMPLE_W-1:0] wr_data;
        logic [ADDR_W-1:0]   rd_addr_a;
        logic [ADDR_W-1:0]   rd_addr_b;
    } mem_req_t;

    typedef struct packed {
        logic [KEPT_W-1:0] kept_sum;
        logic              sum_valid;
    } result_t;

    // true when a sits closer to the heap root than b
    function automatic logic nearer_root(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b,
        input logic                smallest
    );
        return smallest ? (a > b) : (a < b);
    endfunction

    // keep count clamped to 1..MAX_KEEP
    function automatic logic [FILL_W-1:0] effective_keep(input logic [KEEP_W-1:0] kc);
        logic [CMP_W-1:0] kx;
        kx = CMP_W'(kc);
        if (kx == '0)
            return FILL_W'(1);
        else if (kx > CMP_W'(MAX_KEEP))
            return FILL_W'(MAX_KEEP);
        else
            return FILL_W'(kx);
    endfunction

endpackage

// ===== rtl/core/rtksum_if.sv =====
`timescale 1ns / 1ps

interface rtksum_sample_if;
    import rtksum_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                start_sequence;

    modport source (output valid, output sample, output start_sequence, input ready);
    modport sink (input valid, input sample, input start_sequence, output ready);
endinterface

interface rtksum_result_if;
    import rtksum_pkg::*;

    logic              valid;
    logic              ready;
    logic [KEPT_W-1:0] kept_sum;
    logic              sum_valid;

    modport source (output valid, output kept_sum, output sum_valid, input ready);
    modport sink (input valid, input kept_sum, input sum_valid, output ready);
endinterface

interface rtksum_cfg_if;
    import rtksum_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/running_top_k_sum.sv =====
`timescale 1ns / 1ps
// channel   role    accepted when                  payload
// samples   sink    samples.valid && samples.ready sample, start_sequence
// results   source  results.valid && results.ready kept_sum, sum_valid
// cfg       sink    cfg.valid && cfg.ready         index, data
//
// one sample at a time, accept to ready: a dropped sample goes through root,
// finish; a first of a sequence place, finish; an insert up per level tried,
// place, finish; a root replace root, down per level tried, place, finish.
// the result register lets the next sample in while a result waits.
// reset clears fill count, sum and config; heap contents are not cleared.
// cfg is always ready.

module running_top_k_sum (
    input  logic          clk,
    input  logic          rst_n,
    rtksum_sample_if.sink samples,
    rtksum_result_if.source results,
    rtksum_cfg_if.sink    cfg
);
    import rtksum_pkg::*;

    logic [KEEP_W-1:0]   keep_count_reg;
    logic                keep_smallest_reg;
    logic [FILL_W-1:0]   keep_eff;

    logic                seq_idle;
    logic                seq_done;
    logic                seq_take;
    result_t             seq_result;
    mem_req_t            mem_req;
    logic [SAMPLE_W-1:0] rd_data_a;
    logic [SAMPLE_W-1:0] rd_data_b;

    logic                out_valid_reg, out_valid_next;
    result_t             out_data_reg;
    logic                out_load;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg    <= KEEP_W'(1);
            keep_smallest_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_KEEP_COUNT:    keep_count_reg    <= cfg.data[KEEP_W-1:0];
                REG_KEEP_SMALLEST: keep_smallest_reg <= cfg.data[0];
                default:           ;
            endcase
        end
    end

    assign keep_eff = effective_keep(keep_count_reg);

    assign samples.ready = seq_idle;

    rtksum_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (samples.valid && samples.ready),
        .sample         (samples.sample),
        .start_sequence (samples.start_sequence),
        .keep_eff       (keep_eff),
        .keep_smallest  (keep_smallest_reg),
        .idle           (seq_idle),
        .done           (seq_done),
        .take           (seq_take),
        .result         (seq_result),
        .mem_req        (mem_req),
        .rd_data_a      (rd_data_a),
        .rd_data_b      (rd_data_b)
    );

    rtksum_heap_mem u_mem (
        .clk       (clk),
        .req       (mem_req),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // result register: free when empty or being drained
    assign seq_take       = !out_valid_reg || results.ready;
    assign out_load       = seq_done && seq_take;
    assign out_valid_next = out_load || (out_valid_reg && !results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= seq_result;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.kept_sum  = out_data_reg.kept_sum;
    assign results.sum_valid = out_data_reg.sum_valid;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> !samples.ready)
        else $error("sample accepted while previous one still in work");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_done && !seq_take) |=> seq_done)
        else $error("finished result dropped before the result register took it");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_done && seq_take) |=> results.valid)
        else $error("finished result did not reach the result register");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        samples.ready |-> !mem_req.wr_en)
        else $error("heap written while sequencer idle");

endmodule

// ===== rtl/core/rtksum_heap_mem.sv =====
`timescale 1ns / 1ps

module rtksum_heap_mem (
    input  logic                          clk,
    input  rtksum_pkg::mem_req_t          req,
    output logic [rtksum_pkg::SAMPLE_W-1:0] rd_data_a,
    output logic [rtksum_pkg::SAMPLE_W-1:0] rd_data_b
);
    import rtksum_pkg::*;

    logic [SAMPLE_W-1:0] heap_mem [MAX_KEEP];
    logic [SAMPLE_W-1:0] rd_data_a_reg;
    logic [SAMPLE_W-1:0] rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            heap_mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_a_reg <= heap_mem[req.rd_addr_a];
        rd_data_b_reg <= heap_mem[req.rd_addr_b];
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// ===== rtl/core/rtksum_seq.sv =====
`timescale 1ns / 1ps

module rtksum_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [rtksum_pkg::SAMPLE_W-1:0] sample,
    input  logic                            start_sequence,
    input  logic [rtksum_pkg::FILL_W-1:0]   keep_eff,
    input  logic                            keep_smallest,
    output logic                            idle,
    output logic                            done,
    input  logic                            take,
    output rtksum_pkg::result_t             result,
    output rtksum_pkg::mem_req_t            mem_req,
    input  logic [rtksum_pkg::SAMPLE_W-1:0] rd_data_a,
    input  logic [rtksum_pkg::SAMPLE_W-1:0] rd_data_b
);
    import rtksum_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_UP     = 6'b000010,
        ST_ROOT   = 6'b000100,
        ST_DOWN   = 6'b001000,
        ST_PLACE  = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [SAMPLE_W-1:0] x_reg, x_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;

    logic [FILL_W-1:0]   fill_eff;
    logic [POS_W-1:0]    n_pos;
    logic [POS_W-1:0]    idx_pos;
    logic [POS_W-1:0]    up_parent;
    logic [POS_W-1:0]    child_l;
    logic [POS_W-1:0]    child_pos;
    logic [POS_W-1:0]    grand_l;
    logic                take_right;
    logic [SAMPLE_W-1:0] child_val;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        x_next     = x_reg;
        fill_next  = fill_reg;
        sum_next   = sum_reg;
        mem_req    = '0;

        fill_eff   = start_sequence ? '0 : fill_reg;
        n_pos      = POS_W'(fill_reg);
        idx_pos    = POS_W'(idx_reg);
        up_parent  = (idx_pos - POS_W'(1)) >> 1;
        child_l    = (idx_pos << 1) + POS_W'(1);
        take_right = ((child_l + POS_W'(1)) < n_pos)
                     && nearer_root(rd_data_b, rd_data_a, keep_smallest);
        child_pos  = take_right ? (child_l + POS_W'(1)) : child_l;
        child_val  = take_right ? rd_data_b : rd_data_a;
        grand_l    = (child_pos << 1) + POS_W'(1);

        case (state_reg)
            ST_IDLE:
            begin
                // root on port a, parent of the append slot on port b
                mem_req.rd_addr_a = '0;
                mem_req.rd_addr_b = ADDR_W'((POS_W'(fill_eff) - POS_W'(1)) >> 1);
                if (start)
                begin
                    x_next = sample;
                    if (fill_eff < keep_eff)
                    begin
                        fill_next  = fill_eff + FILL_W'(1);
                        sum_next   = (start_sequence ? '0 : sum_reg) + SUM_W'(sample);
                        idx_next   = ADDR_W'(fill_eff);
                        state_next = (fill_eff == '0) ? ST_PLACE : ST_UP;
                    end
                    else
                    begin
                        state_next = ST_ROOT;
                    end
                end
            end
            ST_UP:
            begin
                if (nearer_root(x_reg, rd_data_b, keep_smallest))
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = idx_reg;
                    mem_req.wr_data = rd_data_b;
                    idx_next        = ADDR_W'(up_parent);
                    if (up_parent == '0)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        mem_req.rd_addr_b = ADDR_W'((up_parent - POS_W'(1)) >> 1);
                    end
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_ROOT:
            begin
                // equal to the root means the sample is dropped
                if (nearer_root(rd_data_a, x_reg, keep_smallest))
                begin
                    sum_next = sum_reg + SUM_W'(x_reg) - SUM_W'(rd_data_a);
                    idx_next = '0;
                    if (POS_W'(1) < n_pos)
                    begin
                        mem_req.rd_addr_a = ADDR_W'(POS_W'(1));
                        mem_req.rd_addr_b = ADDR_W'(POS_W'(2));
                        state_next        = ST_DOWN;
                    end
                    else
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DOWN:
            begin
                if (nearer_root(child_val, x_reg, keep_smallest))
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = idx_reg;
                    mem_req.wr_data = child_val;
                    idx_next        = ADDR_W'(child_pos);
                    if (grand_l < n_pos)
                    begin
                        mem_req.rd_addr_a = ADDR_W'(grand_l);
                        mem_req.rd_addr_b = ADDR_W'(grand_l + POS_W'(1));
                    end
                    else
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg;
                mem_req.wr_data = x_reg;
                state_next      = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        x_reg   <= x_next;
    end

    assign idle = (state_reg == ST_IDLE);
    assign done = (state_reg == ST_FINISH);

    // saturate at the width of the result field
    assign result.kept_sum  = (sum_reg[SUM_W-1:KEPT_W] != '0) ? '1 : sum_reg[KEPT_W-1:0];
    assign result.sum_valid = (fill_reg >= keep_eff);

endmodule

// ===== dv/running_top_k_sum_test.sv =====
`timescale 1ns / 1ps

import rtksum_pkg::*;

class kept_sum_tracker;
    logic [SAMPLE_W-1:0]   heap [MAX_KEEP];
    int unsigned           fill;
    logic [SUM_W-1:0]      total;
    logic [KEEP_W-1:0]     keep_count;
    logic                  keep_smallest;
    result_t               expected_sums [$];
    int unsigned           failures;

    function new();
        fill          = 0;
        total         = '0;
        keep_count    = KEEP_W'(1);
        keep_smallest = 1'b0;
        failures      = 0;
    endfunction

    function void flag(string msg);
        failures++;
        if (failures <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function bit closer(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
        return keep_smallest ? (a > b) : (a < b);
    endfunction

    function int unsigned keep_limit();
        if (keep_count == '0)
            return 1;
        if (keep_count > KEEP_W'(MAX_KEEP))
            return MAX_KEEP;
        return 32'(keep_count);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        if (idx == REG_KEEP_COUNT)
            keep_count = value[KEEP_W-1:0];
        else if (idx == REG_KEEP_SMALLEST)
            keep_smallest = value[0];
    endfunction

    function void sift_up(logic [SAMPLE_W-1:0] x);
        int unsigned i;
        int unsigned p;
        i = fill;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (!closer(x, heap[p]))
                break;
            heap[i] = heap[p];
            i = p;
        end
        heap[i] = x;
        fill++;
    endfunction

    function void sift_down_root(logic [SAMPLE_W-1:0] x);
        int unsigned i;
        int unsigned l;
        int unsigned c;
        i = 0;
        forever
        begin
            l = 2 * i + 1;
            if (l >= fill)
                break;
            c = l;
            // right child only when strictly nearer the root
            if (l + 1 < fill && closer(heap[l + 1], heap[l]))
                c = l + 1;
            if (!closer(heap[c], x))
                break;
            heap[i] = heap[c];
            i = c;
        end
        heap[i] = x;
    endfunction

    function void take_sample(logic [SAMPLE_W-1:0] x, logic start);
        int unsigned         k;
        logic [SAMPLE_W-1:0] root;
        result_t             want;
        k = keep_limit();
        if (start)
        begin
            fill  = 0;
            total = '0;
        end
        if (fill < k)
        begin
            sift_up(x);
            total = total + SUM_W'(x);
        end
        else
        begin
            root = heap[0];
            // a tie with the root drops the sample
            if (closer(root, x))
            begin
                sift_down_root(x);
                total = total + SUM_W'(x) - SUM_W'(root);
            end
        end
        want.kept_sum  = ((total >> KEPT_W) != 0) ? '1 : total[KEPT_W-1:0];
        want.sum_valid = (fill >= k);
        expected_sums.push_back(want);
    endfunction

    function void check_result(logic [KEPT_W-1:0] kept_sum, logic sum_valid);
        result_t want;
        if (expected_sums.size() == 0)
        begin
            flag($sformatf("unexpected result kept_sum=%0d sum_valid=%0b",
                           kept_sum, sum_valid));
            return;
        end
        want = expected_sums.pop_front();
        if (kept_sum !== want.kept_sum)
            flag($sformatf("kept_sum expected %0d got %0d", want.kept_sum, kept_sum));
        if (sum_valid !== want.sum_valid)
            flag($sformatf("sum_valid expected %0b got %0b", want.sum_valid, sum_valid));
    endfunction
endclass

module running_top_k_sum_test;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASE_SAMPLES    = 40;
    localparam int RANDOM_PHASES    = 11;

    logic clk;
    logic rst_n;

    rtksum_sample_if samples_ch ();
    rtksum_result_if results_ch ();
    rtksum_cfg_if    cfg_ch ();

    running_top_k_sum DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    kept_sum_tracker tracker;
    bit              tx_idle;
    bit              rx_idle;
    bit              hold_long;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic drive_sample(input logic [SAMPLE_W-1:0] value, input logic start);
        int gap;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            samples_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        samples_ch.valid          = 1'b1;
        samples_ch.sample         = value;
        samples_ch.start_sequence = start;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        tracker.take_sample(value, start);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        tracker.set_reg(idx, value);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        samples_ch.valid = 1'b0;
        while (tracker.expected_sums.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return SAMPLE_W'($urandom_range(0, 15));
            1: return $urandom() | 32'hF000_0000;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return SAMPLE_W'(1);
                    2: return 32'hFFFF_FFFE;
                    default: return '1;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_keep_count();
        case ($urandom_range(0, 7))
            0: return CFG_DATA_W'($urandom_range(0, 3));
            1: return CFG_DATA_W'($urandom_range(1, 64));
            2: return CFG_DATA_W'($urandom());
            default: return CFG_DATA_W'($urandom_range(1, 16));
        endcase
    endfunction

    // receiver side, stalls per result and once for a long stretch
    initial
    begin
        int stall;
        results_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = 0;
            if (hold_long)
            begin
                hold_long = 1'b0;
                stall     = LONG_HOLD_CYCLES;
            end
            else if (rx_idle)
                stall = $urandom_range(0, 14);
            if (stall > 0)
            begin
                results_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            results_ch.ready = 1'b1;
            @(posedge clk);
            while (!results_ch.valid)
                @(posedge clk);
            tracker.check_result(results_ch.kept_sum, results_ch.sum_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] kc;
        logic                  start;
        tracker                   = new();
        tx_idle                   = 1'b1;
        rx_idle                   = 1'b1;
        hold_long                 = 1'b0;
        samples_ch.valid          = 1'b0;
        samples_ch.sample         = '0;
        samples_ch.start_sequence = 1'b0;
        cfg_ch.valid              = 1'b0;
        cfg_ch.index              = REG_KEEP_COUNT;
        cfg_ch.data               = '0;
        rst_n                     = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset config: keep the single largest, ties on the root dropped
        drive_sample(32'd5, 1'b0);
        drive_sample(32'd3, 1'b0);
        drive_sample(32'd5, 1'b0);
        drive_sample(32'hFFFF_FFFF, 1'b0);
        drive_sample(32'd0, 1'b0);
        drive_sample(32'hFFFF_FFFF, 1'b0);

        // zero keep count acts as one, smallest mode
        wait_drained();
        write_reg(REG_KEEP_COUNT, '0);
        write_reg(REG_KEEP_SMALLEST, CFG_DATA_W'(1));
        drive_sample(32'd7, 1'b1);
        drive_sample(32'd9, 1'b0);
        drive_sample(32'd2, 1'b0);
        drive_sample(32'd2, 1'b0);
        drive_sample(32'd0, 1'b0);

        wait_drained();
        write_reg(REG_KEEP_COUNT, CFG_DATA_W'(3));
        write_reg(REG_KEEP_SMALLEST, CFG_DATA_W'(0));
        drive_sample(32'd10, 1'b1);
        drive_sample(32'd20, 1'b0);
        drive_sample(32'd30, 1'b0);
        drive_sample(32'd5, 1'b0);
        drive_sample(32'd40, 1'b0);
        drive_sample(32'd20, 1'b0);

        // flip the ordering with the heap still populated
        wait_drained();
        write_reg(REG_KEEP_SMALLEST, CFG_DATA_W'(1));
        drive_sample(32'd1, 1'b0);
        drive_sample(32'd50, 1'b0);

        // lower the keep count below the current fill
        wait_drained();
        write_reg(REG_KEEP_COUNT, CFG_DATA_W'(2));
        drive_sample(32'd0, 1'b0);
        drive_sample(32'd100, 1'b0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_drained();
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            case (ph)
                2:       kc = CFG_DATA_W'(MAX_KEEP);
                5:       kc = '1;
                8:       kc = '0;
                default: kc = pick_keep_count();
            endcase
            // receiver sits on its results while requests keep coming
            if (ph == 4)
            begin
                kc        = CFG_DATA_W'(4);
                hold_long = 1'b1;
                tx_idle   = 1'b0;
            end
            // sometimes carry the old settings or the old sequence over
            if (ph < 2 || $urandom_range(0, 4) != 0)
                write_reg(REG_KEEP_COUNT, kc);
            if ($urandom_range(0, 1) != 0)
                write_reg(REG_KEEP_SMALLEST, CFG_DATA_W'($urandom_range(0, 1)));
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
                          CFG_DATA_W'($urandom()));
            for (int n = 0; n < PHASE_SAMPLES; n++)
            begin
                if (n == 0)
                    start = ($urandom_range(0, 2) != 0);
                else
                    start = ($urandom_range(0, 24) == 0);
                drive_sample(pick_sample(), start);
            end
        end

        wait_drained();
        repeat (30) @(negedge clk);
        if (tracker.expected_sums.size() != 0)
            tracker.flag($sformatf("%0d results never arrived",
                                   tracker.expected_sums.size()));
        if (tracker.failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== running_top_k_sum.f =====
rtl/core/rtksum_pkg.sv
rtl/core/rtksum_if.sv
rtl/core/rtksum_heap_mem.sv
rtl/core/rtksum_seq.sv
rtl/core/running_top_k_sum.sv
dv/running_top_k_sum_test.sv
